@@ hdl/qwvs_pkg.sv @@
// Shared types and constants for the quaternion vertex skinning core.
// No dependencies.
package qwvs_pkg;
  localparam int unsigned JointAw = 8;
  localparam int unsigned Joints  = 256;
  localparam int unsigned SumW    = 48;
  localparam logic signed [SumW-1:0] SumMax = {1'b0, {(SumW-1){1'b1}}};
  localparam logic signed [SumW-1:0] SumMin = {1'b1, {(SumW-1){1'b0}}};

  // Joint table entry: position plus orientation (w,x,y,z).
  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [15:0] qz;
    logic signed [15:0] qy;
    logic signed [15:0] qx;
    logic signed [15:0] qw;
  } joint_t;

  localparam int unsigned JointW = $bits(joint_t);
endpackage

@@ hdl/quaternion_weighted_vertex_skinning_core.sv @@
// Top level of the quaternion linear blend skinning core.
// Depends on qwvs_pkg, qwvs_ram, qwvs_mac and qwvs_sqrt.
//
// Channel | Dir | Signals                       | Contents
// in_     | in  | tvalid tready tdata tuser tlast | joint, pos, rot, weight; kind; last
// out_    | out | tvalid tready tdata tuser       | vertex x,y,z; saturated
//
// A joint write holds the core after acceptance for the radicand steps,
// the bit-serial square root of w and the table write.
// A weight request holds it for the table read, the first product
// (three terms and a settle step per component), the second (four terms
// and a rounding step per component) and the three weight products, all on
// one shared 38x18 multiplier-adder; a last weight adds the load step.
// Reset clears the sequencer, the running sums and the output valid; the
// joint table holds no reset. in_tready is high only in idle, so no new
// request is taken before the last is done. A finished result waits in the
// output register; the load step holds while that register is still full.
module quaternion_weighted_vertex_skinning_core
  import qwvs_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // tdata: joint[7:0], pos_x[39:8], pos_y[71:40], pos_z[103:72],
  //        rot_x[119:104], rot_y[135:120], rot_z[151:136], weight[167:152]
  input  logic [167:0] in_tdata,
  input  logic         in_tuser,   // kind
  input  logic         in_tlast,   // last
  output logic         out_tvalid,
  input  logic         out_tready,
  // tdata: vert_x[31:0], vert_y[63:32], vert_z[95:64]
  output logic [95:0]  out_tdata,
  output logic         out_tuser   // saturated
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SQ   = 4'd1;  // radicand terms
  localparam logic [3:0] S_SQW  = 4'd2;  // square root running
  localparam logic [3:0] S_WR   = 4'd3;  // write joint entry
  localparam logic [3:0] S_RD   = 4'd4;  // joint read latency
  localparam logic [3:0] S_P1   = 4'd5;  // first product terms
  localparam logic [3:0] S_P2   = 4'd6;  // second product terms
  localparam logic [3:0] S_WT   = 4'd7;  // weight terms
  localparam logic [3:0] S_OUT  = 4'd8;  // load result

  logic [3:0] st_r, st_nxt;
  logic [3:0] k_r, k_nxt;   // term counter
  logic [1:0] c_r, c_nxt;   // component counter

  logic [167:0] req_r;
  logic         kind_r, last_r;
  logic signed [31:0] vx, vy, vz;
  logic signed [15:0] rx, ry, rz;
  logic [15:0]  wgt;
  assign vx  = req_r[39:8];
  assign vy  = req_r[71:40];
  assign vz  = req_r[103:72];
  assign rx  = req_r[119:104];
  assign ry  = req_r[135:120];
  assign rz  = req_r[151:136];
  assign wgt = req_r[167:152];

  // Rotated terms reach about 2^36.3 once the joint position is added.
  logic signed [37:0] t_r [4];
  logic signed [37:0] r_r [3];
  logic signed [SumW-1:0] sum_r [3];
  logic signed [15:0] w_r;

  joint_t jrd, jwr;
  logic   jwe;
  logic in_ok;
  assign in_ok = in_tvalid && in_tready;

  qwvs_ram #(.Width(JointW), .Depth(Joints)) u_tab (
    .clk(clk), .we(jwe), .addr(req_r[JointAw-1:0]), .wdata(jwr), .rdata(jrd)
  );

  // Shared multiplier operands.
  logic signed [37:0] ma;
  logic signed [17:0] mb;
  logic mneg, mclr, men;
  logic signed [63:0] acc;

  qwvs_mac u_mac (
    .clk(clk), .a(ma), .b(mb), .neg(mneg), .clr(mclr), .en(men), .acc(acc)
  );

  logic sq_start, sq_busy;
  logic [14:0] sq_root;
  logic signed [63:0] tq;
  assign tq = 64'sd268435456 - acc;
  qwvs_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_start),
    .radicand(tq[28:0]), .busy(sq_busy), .root(sq_root)
  );

  // Quaternion components as signed 18-bit.
  logic signed [17:0] q0, q1, q2, q3;
  assign q0 = 18'(jrd.qw);
  assign q1 = 18'(jrd.qx);
  assign q2 = 18'(jrd.qy);
  assign q3 = 18'(jrd.qz);

  // Term tables: select operands by component c and term k.
  always_comb begin
    ma = '0; mb = '0; mneg = 1'b0;
    mclr = (k_r == 4'd0); men = 1'b0;
    unique case (st_r)
      S_SQ: begin
        // Three squares, then hold the sum while the root starts.
        men = 1'b1;
        unique case (k_r[1:0])
          2'd0:    begin ma = 38'(rx); mb = 18'(rx); end
          2'd1:    begin ma = 38'(ry); mb = 18'(ry); end
          2'd2:    begin ma = 38'(rz); mb = 18'(rz); end
          default: men = 1'b0;
        endcase
      end
      S_P1: begin
        // t = q * (0,v)
        men = 1'b1;
        unique case ({c_r, k_r[1:0]})
          4'h0: begin ma = 38'(vx); mb = q1; mneg = 1'b1; end
          4'h1: begin ma = 38'(vy); mb = q2; mneg = 1'b1; end
          4'h2: begin ma = 38'(vz); mb = q3; mneg = 1'b1; end
          4'h4: begin ma = 38'(vx); mb = q0; end
          4'h5: begin ma = 38'(vz); mb = q2; end
          4'h6: begin ma = 38'(vy); mb = q3; mneg = 1'b1; end
          4'h8: begin ma = 38'(vy); mb = q0; end
          4'h9: begin ma = 38'(vx); mb = q3; end
          4'hA: begin ma = 38'(vz); mb = q1; mneg = 1'b1; end
          4'hC: begin ma = 38'(vz); mb = q0; end
          4'hD: begin ma = 38'(vy); mb = q1; end
          4'hE: begin ma = 38'(vx); mb = q2; mneg = 1'b1; end
          default: men = 1'b0;
        endcase
      end
      S_P2: begin
        // r = t * conj(q), vector part
        men = 1'b1;
        unique case ({c_r, k_r[1:0]})
          4'h0: begin ma = t_r[1]; mb = q0; end
          4'h1: begin ma = t_r[0]; mb = q1; mneg = 1'b1; end
          4'h2: begin ma = t_r[2]; mb = q3; mneg = 1'b1; end
          4'h3: begin ma = t_r[3]; mb = q2; end
          4'h4: begin ma = t_r[2]; mb = q0; end
          4'h5: begin ma = t_r[0]; mb = q2; mneg = 1'b1; end
          4'h6: begin ma = t_r[3]; mb = q1; mneg = 1'b1; end
          4'h7: begin ma = t_r[1]; mb = q3; end
          4'h8: begin ma = t_r[3]; mb = q0; end
          4'h9: begin ma = t_r[0]; mb = q3; mneg = 1'b1; end
          4'hA: begin ma = t_r[1]; mb = q2; mneg = 1'b1; end
          4'hB: begin ma = t_r[2]; mb = q1; end
          default: men = 1'b0;
        endcase
      end
      S_WT: begin
        men = (k_r == 4'd0);
        mclr = 1'b1;
        ma = r_r[c_r[1:0] == 2'd3 ? 2'd0 : c_r[1:0]];
        mb = 18'({2'b00, wgt});
      end
      default: ;
    endcase
  end

  // floor((a + 2^(s-1)) >> s) is an arithmetic shift after the bias add.
  logic signed [63:0] rnd14, rnd15;
  assign rnd14 = (acc + 64'sd8192) >>> 14;
  assign rnd15 = (acc + 64'sd16384) >>> 15;

  // Weighted add with 48-bit saturation.
  logic [1:0] ci;
  logic signed [SumW+16:0] sadd;
  logic signed [SumW-1:0] ssat;
  assign ci   = (c_r == 2'd3) ? 2'd0 : c_r;
  assign sadd = (SumW+17)'(sum_r[ci]) + (SumW+17)'(rnd15);
  always_comb begin
    priority if (sadd > (SumW+17)'(SumMax)) ssat = SumMax;
    else if (sadd < (SumW+17)'(SumMin)) ssat = SumMin;
    else ssat = sadd[SumW-1:0];
  end

  // Clamp to 32 bits.
  function automatic logic [32:0] clamp32(input logic signed [SumW-1:0] v);
    logic [32:0] r;
    if (v > 48'sh00007FFFFFFF) r = {1'b1, 32'h7FFFFFFF};
    else if (v < -48'sh000080000000) r = {1'b1, 32'h80000000};
    else r = {1'b0, v[31:0]};
    return r;
  endfunction

  logic [32:0] cx, cy, cz;
  assign cx = clamp32(sum_r[0]);
  assign cy = clamp32(sum_r[1]);
  assign cz = clamp32(sum_r[2]);

  logic [95:0] od_r;
  logic        os_r, ov_r;
  logic        out_load;

  // Load the result once the output register is free or drains this cycle.
  assign out_load = (st_r == S_OUT) && (!ov_r || out_tready);

  always_comb begin
    jwr = '{px: vx, py: vy, pz: vz, qz: rz, qy: ry, qx: rx, qw: w_r};
  end
  assign jwe = (st_r == S_WR) && (req_r[JointAw-1:0] < 8'(Joints - 1) ||
                                  req_r[JointAw-1:0] == 8'(Joints - 1));

  // The first product takes three terms per component plus a settle step,
  // the second four terms plus a rounding step; the accumulator result is
  // ready in the cycle after the last term.
  always_comb begin
    st_nxt = st_r; k_nxt = k_r; c_nxt = c_r; sq_start = 1'b0;
    unique case (st_r)
      S_IDLE: if (in_ok) begin
        st_nxt = in_tuser ? S_RD : S_SQ; k_nxt = '0; c_nxt = '0;
      end
      S_SQ: begin
        k_nxt = k_r + 4'd1;
        if (k_r == 4'd3) begin st_nxt = S_SQW; sq_start = 1'b1; end
      end
      S_SQW: if (!sq_busy) st_nxt = S_WR;
      S_WR: st_nxt = S_IDLE;
      S_RD: st_nxt = S_P1;
      S_P1: begin
        k_nxt = k_r + 4'd1;
        if (k_r == 4'd3) begin
          k_nxt = '0; c_nxt = c_r + 2'd1;
          if (c_r == 2'd3) st_nxt = S_P2;
        end
      end
      S_P2: begin
        k_nxt = k_r + 4'd1;
        if (k_r == 4'd4) begin
          k_nxt = '0; c_nxt = c_r + 2'd1;
          if (c_r == 2'd2) begin c_nxt = '0; st_nxt = S_WT; end
        end
      end
      S_WT: begin
        k_nxt = k_r + 4'd1;
        if (k_r == 4'd1) begin
          k_nxt = '0; c_nxt = c_r + 2'd1;
          if (c_r == 2'd2) st_nxt = last_r ? S_OUT : S_IDLE;
        end
      end
      // Hold here while the previous result still waits.
      S_OUT: if (!ov_r || out_tready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  assign in_tready = (st_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; k_r <= '0; c_r <= '0; ov_r <= 1'b0;
      sum_r[0] <= '0; sum_r[1] <= '0; sum_r[2] <= '0;
    end else begin
      st_r <= st_nxt; k_r <= k_nxt; c_r <= c_nxt;
      if (st_r == S_WT && k_r == 4'd1) sum_r[ci] <= ssat;
      if (out_load) begin
        ov_r <= 1'b1;
        sum_r[0] <= '0; sum_r[1] <= '0; sum_r[2] <= '0;
      end else if (out_tready) begin
        ov_r <= 1'b0;
      end
    end
    if (in_ok) begin
      req_r <= in_tdata; kind_r <= in_tuser; last_r <= in_tlast;
    end
    // Capture w: negative radicand gives zero.
    if (st_r == S_SQ && k_r == 4'd3) w_r <= '0;
    if (st_r == S_SQW && !sq_busy && !tq[63]) w_r <= -$signed({1'b0, sq_root});
    // Product term 3 of P1 is idle; its cycle lets the accumulator settle.
    if (st_r == S_P1 && k_r == 4'd3) t_r[c_r] <= 38'(rnd14);
    if (st_r == S_P2 && k_r == 4'd4) r_r[c_r[1:0] == 2'd3 ? 2'd0 : c_r] <=
      38'(rnd14 + 64'(c_r == 2'd0 ? jrd.px : c_r == 2'd1 ? jrd.py : jrd.pz));
    if (out_load) begin
      od_r <= {cz[31:0], cy[31:0], cx[31:0]};
      os_r <= cx[32] | cy[32] | cz[32];
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = os_r;

  // A waiting result holds still until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while waiting");
  // A result appears only after the output load step.
  a_out_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(st_r) == S_OUT) else $error("stray result");
  // The joint table is written only for joint-write requests.
  a_we_kind: assert property (@(posedge clk) disable iff (!rst_n)
    jwe |-> !kind_r) else $error("table write on weight request");
endmodule

@@ hdl/qwvs_ram.sv @@
// Generic single-port RAM with registered read.
// No dependencies.
module qwvs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

@@ hdl/qwvs_mac.sv @@
// Shared signed multiply-accumulate unit, accumulator registered.
// Depends on nothing; used by the top-level sequencer.
module qwvs_mac (
  input  logic               clk,
  input  logic signed [37:0] a,
  input  logic signed [17:0] b,
  input  logic               neg,
  input  logic               clr,
  input  logic               en,
  output logic signed [63:0] acc
);
  logic signed [63:0] acc_r;
  logic signed [63:0] prod;

  assign prod = 64'(a) * 64'(b);

  always_ff @(posedge clk) begin
    if (en) begin
      acc_r <= (clr ? 64'sd0 : acc_r) + (neg ? -prod : prod);
    end
  end

  assign acc = acc_r;
endmodule

@@ hdl/qwvs_sqrt.sv @@
// Bit-serial integer square root, one result bit per cycle.
// Depends on nothing.
module qwvs_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [28:0] radicand,
  output logic        busy,
  output logic [14:0] root
);
  logic [28:0] n_r, n_nxt;
  logic [28:0] res_r, res_nxt;
  logic [28:0] bit_r, bit_nxt;
  logic        busy_r, busy_nxt;

  always_comb begin
    n_nxt    = n_r;
    res_nxt  = res_r;
    bit_nxt  = bit_r;
    busy_nxt = busy_r;
    if (start) begin
      n_nxt    = radicand;
      res_nxt  = '0;
      bit_nxt  = 29'd1 << 28;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (n_r >= res_r + bit_r) begin
        n_nxt   = n_r - (res_r + bit_r);
        res_nxt = (res_r >> 1) + bit_r;
      end else begin
        res_nxt = res_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      if (bit_r == 29'd1) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    n_r   <= n_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
  end

  assign busy = busy_r;
  assign root = res_r[14:0];
endmodule
